[sv/dpst_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the dense Prim spanning tree block.
// No dependencies; used by every other file of the block.
package dpst_pkg;

    localparam int MAX_VERTICES = 32;
    localparam int WEIGHT_BITS  = 16;

    localparam int STORE_DEPTH  = MAX_VERTICES * MAX_VERTICES;
    localparam int VIDX_W       = $clog2(MAX_VERTICES);
    localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
    localparam int ADDR_W       = $clog2(STORE_DEPTH);
    localparam int TOTAL_W      = $clog2(STORE_DEPTH + 1);
    localparam int PROD_W       = VIDX_W + CNT_W;
    localparam int KEY_W        = WEIGHT_BITS + 1;

    localparam logic [KEY_W-1:0] KEY_INF = KEY_W'(1) << WEIGHT_BITS;

    typedef struct packed {
        logic                   present;
        logic [WEIGHT_BITS-1:0] weight;
    } edge_entry_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } edge_rd_t;

    typedef struct packed {
        logic              valid;
        logic [VIDX_W-1:0] vertex;
        logic [VIDX_W-1:0] parent;
        logic              has_parent;
        logic              last;
    } result_t;

    typedef enum logic [2:0] {
        E_IDLE,
        E_INIT,
        E_SELECT,
        E_PICK,
        E_UPDATE,
        E_TAIL,
        E_EMIT
    } eng_state_t;

endpackage

[sv/dense_prim_spanning_tree_core.sv]
`timescale 1ns / 1ps
// Top level of the dense Prim minimum spanning tree block.
// Depends on dpst_pkg, dpst_edge_ram and dpst_prim_engine.
//
// Usage:
//   Write vertex_count (n) through cfg_wr_en / vertex_count while the block is
//   idle; 0 acts as 1, values above 32 act as 32. A write restarts loading at
//   matrix entry 0.
//   Feed the n*n matrix entries in row-major order (row = from-vertex), one
//   beat per cycle: a beat is taken at each edge with start high and busy low.
//   After the last entry busy rises and Prim's algorithm runs from vertex 0.
//   Then n result beats follow on consecutive cycles, marked by result_valid,
//   vertex 0 first; last_vertex flags the final one. The receiver cannot stall
//   the block: each result beat is on the ports for exactly one cycle.
// Compute:
//   After init, each vertex that joins the tree costs a select scan over the
//   keys and an update scan over its matrix row; one final empty select scan
//   ends the computation, then the results go out. The pace is set by the one
//   read port of the edge store and the single key comparator, each scanning
//   a row per pass.
// Reset:
//   Asynchronous, active low. Clears the sequencer and the load position and
//   sets vertex_count to 1. The matrix store keeps no reset value.
module dense_prim_spanning_tree_core (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_wr_en,
    input  logic [dpst_pkg::CNT_W-1:0]             vertex_count,
    input  logic                                   start,
    output logic                                   busy,
    input  logic                                   edge_present,
    input  logic [15:0]                            edge_weight,
    output logic                                   result_valid,
    output logic [dpst_pkg::VIDX_W-1:0]            vertex_index,
    output logic [dpst_pkg::VIDX_W-1:0]            parent_index,
    output logic                                   has_parent,
    output logic                                   last_vertex
);

    localparam int CNT_W   = dpst_pkg::CNT_W;
    localparam int ADDR_W  = dpst_pkg::ADDR_W;
    localparam int TOTAL_W = dpst_pkg::TOTAL_W;

    logic [CNT_W-1:0]   n_reg, n_next;
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic [ADDR_W-1:0]  load_pos_reg, load_pos_next;

    logic                  accept;
    logic                  load_done;
    dpst_pkg::edge_entry_t wr_data;
    dpst_pkg::edge_rd_t    rd;
    dpst_pkg::edge_entry_t rd_data;
    dpst_pkg::result_t     res;

    // take a beat only when the sequencer is parked
    assign accept    = start && !busy;
    assign load_done = accept
                       && ((TOTAL_W'(load_pos_reg) + TOTAL_W'(1)) == total_reg);

    assign wr_data.present = edge_present;
    assign wr_data.weight  = edge_weight[dpst_pkg::WEIGHT_BITS-1:0];

    // clamp the written count and precompute the matrix size
    always_comb
    begin
        if (vertex_count == '0)
        begin
            n_next = CNT_W'(1);
        end
        else if (vertex_count > CNT_W'(dpst_pkg::MAX_VERTICES))
        begin
            n_next = CNT_W'(dpst_pkg::MAX_VERTICES);
        end
        else
        begin
            n_next = vertex_count;
        end
        total_next = TOTAL_W'(n_next) * TOTAL_W'(n_next);
    end

    // advance the load position per beat; wrap when the matrix is full
    always_comb
    begin
        load_pos_next = load_pos_reg;
        if (cfg_wr_en)
        begin
            load_pos_next = '0;
        end
        else if (load_done)
        begin
            load_pos_next = '0;
        end
        else if (accept)
        begin
            load_pos_next = load_pos_reg + ADDR_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg        <= CNT_W'(1);
            total_reg    <= TOTAL_W'(1);
            load_pos_reg <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                n_reg     <= n_next;
                total_reg <= total_next;
            end
            load_pos_reg <= load_pos_next;
        end
    end

    dpst_edge_ram u_edge_ram (
        .clk     (clk),
        .wr_en   (accept),
        .wr_addr (load_pos_reg),
        .wr_data (wr_data),
        .rd      (rd),
        .rd_data (rd_data)
    );

    dpst_prim_engine u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .go      (load_done),
        .n       (n_reg),
        .rd      (rd),
        .rd_data (rd_data),
        .busy    (busy),
        .res     (res)
    );

    assign result_valid = res.valid;
    assign vertex_index = res.vertex;
    assign parent_index = res.parent;
    assign has_parent   = res.has_parent;
    assign last_vertex  = res.last;

    // results only come out of a running computation
    a_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> busy)
        else $error("result beat while idle");

    // the final result returns the block to idle
    a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && last_vertex) |=> !busy)
        else $error("block still busy after last result");

    // results walk the vertices in order without gaps
    a_results_in_order: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !last_vertex) |=>
            (result_valid && vertex_index == $past(vertex_index) + 1'b1))
        else $error("result beats out of order");

    // a vertex is never its own parent
    a_no_self_parent: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && has_parent) |-> (parent_index != vertex_index))
        else $error("vertex reported as its own parent");

endmodule

[sv/dpst_edge_ram.sv]
`timescale 1ns / 1ps
// Adjacency matrix store: one write port, one registered read port.
// Depends on dpst_pkg.
module dpst_edge_ram (
    input  logic                        clk,
    input  logic                        wr_en,
    input  logic [dpst_pkg::ADDR_W-1:0] wr_addr,
    input  dpst_pkg::edge_entry_t       wr_data,
    input  dpst_pkg::edge_rd_t          rd,
    output dpst_pkg::edge_entry_t       rd_data
);

    dpst_pkg::edge_entry_t mem [dpst_pkg::STORE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            rd_data <= mem[rd.addr];
        end
    end

endmodule

[sv/dpst_prim_engine.sv]
`timescale 1ns / 1ps
// Prim sequencer: per-vertex keys, marks and parents, one shared key comparator.
// Depends on dpst_pkg; reads the matrix through dpst_edge_ram.
module dpst_prim_engine (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       go,
    input  logic [dpst_pkg::CNT_W-1:0] n,
    output dpst_pkg::edge_rd_t         rd,
    input  dpst_pkg::edge_entry_t      rd_data,
    output logic                       busy,
    output dpst_pkg::result_t          res
);

    localparam int VIDX_W = dpst_pkg::VIDX_W;
    localparam int KEY_W  = dpst_pkg::KEY_W;
    localparam int ADDR_W = dpst_pkg::ADDR_W;

    dpst_pkg::eng_state_t state_reg, state_next;
    logic [VIDX_W-1:0] v_reg, v_next;
    logic [VIDX_W-1:0] vd_reg, vd_next;
    logic              rd_valid_reg, rd_valid_next;
    logic [VIDX_W-1:0] u_reg, u_next;
    logic [KEY_W-1:0]  best_reg, best_next;
    logic              found_reg, found_next;
    logic [ADDR_W-1:0] row_base_reg, row_base_next;

    logic [KEY_W-1:0]  key_reg     [dpst_pkg::MAX_VERTICES];
    logic              visited_reg [dpst_pkg::MAX_VERTICES];
    logic [VIDX_W-1:0] parent_reg  [dpst_pkg::MAX_VERTICES];
    logic              pvalid_reg  [dpst_pkg::MAX_VERTICES];

    logic [VIDX_W-1:0] idx;
    logic [KEY_W-1:0]  key_rd;
    logic              visited_rd;
    logic [VIDX_W-1:0] parent_rd;
    logic              pvalid_rd;
    logic [KEY_W-1:0]  cmp_a;
    logic [KEY_W-1:0]  cmp_b;
    logic              lt;
    logic              v_last;
    logic              init_all;
    logic              key_we;
    logic              visit_we;

    // one read port on the vertex arrays: the pending edge in the update and tail states, else the scan index
    assign idx        = (state_reg == dpst_pkg::E_UPDATE || state_reg == dpst_pkg::E_TAIL)
                        ? vd_reg : v_reg;
    assign key_rd     = key_reg[idx];
    assign visited_rd = visited_reg[idx];
    assign parent_rd  = parent_reg[idx];
    assign pvalid_rd  = pvalid_reg[idx];
    assign v_last     = (dpst_pkg::CNT_W'(v_reg) == n - dpst_pkg::CNT_W'(1));

    // shared key comparator
    assign lt = (cmp_a < cmp_b);

    always_comb
    begin
        state_next    = state_reg;
        v_next        = v_reg;
        vd_next       = v_reg;
        rd_valid_next = 1'b0;
        u_next        = u_reg;
        best_next     = best_reg;
        found_next    = found_reg;
        row_base_next = row_base_reg;
        init_all      = 1'b0;
        key_we        = 1'b0;
        visit_we      = 1'b0;
        rd.en         = 1'b0;
        rd.addr       = row_base_reg + ADDR_W'(v_reg);
        cmp_a         = key_rd;
        cmp_b         = best_reg;
        res.valid      = 1'b0;
        res.vertex     = v_reg;
        res.parent     = pvalid_rd ? parent_rd : '0;
        res.has_parent = pvalid_rd;
        res.last       = 1'b0;

        if (rd_valid_reg)
        begin
            cmp_a = {1'b0, rd_data.weight};
            cmp_b = key_rd;
            key_we = rd_data.present && !visited_rd && lt;
        end

        unique case (state_reg)
            dpst_pkg::E_IDLE:
            begin
                if (go)
                begin
                    state_next = dpst_pkg::E_INIT;
                end
            end
            dpst_pkg::E_INIT:
            begin
                init_all   = 1'b1;
                v_next     = '0;
                best_next  = dpst_pkg::KEY_INF;
                found_next = 1'b0;
                state_next = dpst_pkg::E_SELECT;
            end
            dpst_pkg::E_SELECT:
            begin
                if (!visited_rd && lt)
                begin
                    best_next  = key_rd;
                    u_next     = v_reg;
                    found_next = 1'b1;
                end
                if (v_last)
                begin
                    state_next = dpst_pkg::E_PICK;
                end
                else
                begin
                    v_next = v_reg + VIDX_W'(1);
                end
            end
            dpst_pkg::E_PICK:
            begin
                v_next = '0;
                if (!found_reg)
                begin
                    state_next = dpst_pkg::E_EMIT;
                end
                else
                begin
                    visit_we      = 1'b1;
                    row_base_next = ADDR_W'(dpst_pkg::PROD_W'(u_reg)
                                            * dpst_pkg::PROD_W'(n));
                    state_next    = dpst_pkg::E_UPDATE;
                end
            end
            dpst_pkg::E_UPDATE:
            begin
                rd.en         = 1'b1;
                rd_valid_next = 1'b1;
                if (v_last)
                begin
                    state_next = dpst_pkg::E_TAIL;
                end
                else
                begin
                    v_next = v_reg + VIDX_W'(1);
                end
            end
            dpst_pkg::E_TAIL:
            begin
                v_next     = '0;
                best_next  = dpst_pkg::KEY_INF;
                found_next = 1'b0;
                state_next = dpst_pkg::E_SELECT;
            end
            dpst_pkg::E_EMIT:
            begin
                res.valid = 1'b1;
                res.last  = v_last;
                if (v_last)
                begin
                    state_next = dpst_pkg::E_IDLE;
                end
                else
                begin
                    v_next = v_reg + VIDX_W'(1);
                end
            end
            default:
            begin
                state_next = dpst_pkg::E_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != dpst_pkg::E_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= dpst_pkg::E_IDLE;
            v_reg        <= '0;
            rd_valid_reg <= 1'b0;
            found_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            v_reg        <= v_next;
            rd_valid_reg <= rd_valid_next;
            found_reg    <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        vd_reg       <= vd_next;
        u_reg        <= u_next;
        best_reg     <= best_next;
        row_base_reg <= row_base_next;
    end

    always_ff @(posedge clk)
    begin
        if (init_all)
        begin
            for (int i = 0; i < dpst_pkg::MAX_VERTICES; i++)
            begin
                key_reg[i]     <= (i == 0) ? '0 : dpst_pkg::KEY_INF;
                visited_reg[i] <= 1'b0;
                pvalid_reg[i]  <= 1'b0;
            end
        end
        else
        begin
            if (key_we)
            begin
                key_reg[vd_reg]    <= {1'b0, rd_data.weight};
                parent_reg[vd_reg] <= u_reg;
                pvalid_reg[vd_reg] <= 1'b1;
            end
            if (visit_we)
            begin
                visited_reg[u_reg] <= 1'b1;
            end
        end
    end

endmodule

[sim/dense_prim_spanning_tree_core_tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for dense_prim_spanning_tree_core: loads adjacency matrices, predicts
// the spanning tree parents and compares every result beat. Depends on dpst_pkg and the core.
module dense_prim_spanning_tree_core_tb;

    localparam int MAX_VERTICES = dpst_pkg::MAX_VERTICES;
    localparam int WEIGHT_BITS  = dpst_pkg::WEIGHT_BITS;
    localparam int STORE_DEPTH  = dpst_pkg::STORE_DEPTH;
    localparam int VIDX_W       = dpst_pkg::VIDX_W;
    localparam int CNT_W        = dpst_pkg::CNT_W;
    localparam int KEY_W        = dpst_pkg::KEY_W;
    localparam logic [KEY_W-1:0] KEY_INF = dpst_pkg::KEY_INF;

    localparam int LIMIT_CYCLES = 500000;
    localparam int TAIL_CYCLES  = 2 * MAX_VERTICES * MAX_VERTICES + 4 * MAX_VERTICES + 2;
    localparam int REPORT_MAX   = 10;

    // One expected tree link: the parent reported for one vertex.
    typedef struct packed {
        logic [VIDX_W-1:0] vertex;
        logic [VIDX_W-1:0] parent;
        logic              has_parent;
        logic              last;
    } tree_link_t;

    logic              clk;
    logic              rst_n;
    logic              cfg_wr_en;
    logic [CNT_W-1:0]  vertex_count;
    logic              start;
    logic              busy;
    logic              edge_present;
    logic [15:0]       edge_weight;
    logic              result_valid;
    logic [VIDX_W-1:0] vertex_index;
    logic [VIDX_W-1:0] parent_index;
    logic              has_parent;
    logic              last_vertex;

    // Shadow of the block: count register, load pointer and the matrix itself.
    logic [CNT_W-1:0]      count_setting;
    int unsigned           load_slot;
    dpst_pkg::edge_entry_t edge_matrix [STORE_DEPTH];

    tree_link_t        links_due [$];

    int                sender_idle_pct;
    int                beats_sent;
    int                links_checked;
    int                settings_written;
    int                fail_count;
    int                cycle_count;

    dense_prim_spanning_tree_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .vertex_count (vertex_count),
        .start        (start),
        .busy         (busy),
        .edge_present (edge_present),
        .edge_weight  (edge_weight),
        .result_valid (result_valid),
        .vertex_index (vertex_index),
        .parent_index (parent_index),
        .has_parent   (has_parent),
        .last_vertex  (last_vertex)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Watchdog: a hung block or a lost result ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles, %0d links still due", cycle_count,
                     links_due.size());
            $display("dense_prim_spanning_tree_core_tb failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Map the raw register to the vertex count actually used: 0 runs as a
    // single vertex, anything past the store size is clamped.
    function automatic int used_vertices();
        if (count_setting == 0)
            return 1;
        if (count_setting > MAX_VERTICES)
            return MAX_VERTICES;
        return int'(count_setting);
    endfunction

    // Grow the tree from vertex 0 over the first n*n matrix entries and queue
    // one link per vertex, in index order.
    task automatic grow_tree(int n);
        logic [KEY_W-1:0]      key    [MAX_VERTICES];
        bit                    joined [MAX_VERTICES];
        logic [VIDX_W-1:0]     up     [MAX_VERTICES];
        bit                    linked [MAX_VERTICES];
        logic [KEY_W-1:0]      best;
        int                    u;
        bit                    found;
        dpst_pkg::edge_entry_t e;
        tree_link_t            link;
        for (int v = 0; v < MAX_VERTICES; v++)
        begin
            key[v]    = KEY_INF;
            joined[v] = 1'b0;
            up[v]     = '0;
            linked[v] = 1'b0;
        end
        key[0] = '0;
        for (int i = 0; i < n; i++)
        begin
            best  = KEY_INF;
            u     = 0;
            found = 1'b0;
            // Strict compare keeps the lowest index on a tie.
            for (int v = 0; v < n; v++)
            begin
                if (!joined[v] && key[v] < best)
                begin
                    best  = key[v];
                    u     = v;
                    found = 1'b1;
                end
            end
            // Nothing finite left: the rest of the graph is unreachable.
            if (!found)
                break;
            joined[u] = 1'b1;
            for (int v = 0; v < n; v++)
            begin
                e = edge_matrix[u * n + v];
                if (e.present && !joined[v] && {1'b0, e.weight} < key[v])
                begin
                    key[v]    = {1'b0, e.weight};
                    up[v]     = VIDX_W'(u);
                    linked[v] = 1'b1;
                end
            end
        end
        for (int v = 0; v < n; v++)
        begin
            link.vertex     = VIDX_W'(v);
            link.parent     = linked[v] ? up[v] : '0;
            link.has_parent = linked[v];
            link.last       = (v == n - 1);
            links_due.push_back(link);
        end
    endtask

    // Store one accepted matrix beat; the final entry of a matrix kicks off the tree.
    task automatic store_edge(bit present, logic [15:0] weight);
        int n;
        n = used_vertices();
        edge_matrix[load_slot] = '{present: present, weight: weight[WEIGHT_BITS-1:0]};
        load_slot++;
        if (load_slot == n * n)
        begin
            load_slot = 0;
            grow_tree(n);
        end
    endtask

    // ------------------------------------------------------------------
    // Checker
    // ------------------------------------------------------------------

    task automatic report_failure(string what, tree_link_t want, tree_link_t got);
        fail_count++;
        if (fail_count <= REPORT_MAX)
            $display("%s: expected v%0d p%0d h%0d l%0d, got v%0d p%0d h%0d l%0d", what,
                     want.vertex, want.parent, want.has_parent, want.last,
                     got.vertex, got.parent, got.has_parent, got.last);
    endtask

    // Result beats cannot be stalled: take each one at the edge that ends it.
    always @(posedge clk)
    begin : check_links
        tree_link_t got;
        tree_link_t want;
        if (rst_n && result_valid)
        begin
            got = '{vertex: vertex_index, parent: parent_index,
                    has_parent: has_parent, last: last_vertex};
            if (links_due.size() == 0)
                report_failure("result beat with nothing due", '0, got);
            else
            begin
                want = links_due.pop_front();
                if (got !== want)
                    report_failure("tree link mismatch", want, got);
            end
            links_checked++;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Idle with start low for a random number of cycles, then offer one
    // matrix beat and hold it until the block takes it.
    task automatic send_edge(bit present, logic [15:0] weight);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start        <= 1'b1;
        edge_present <= present;
        edge_weight  <= weight;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        store_edge(present, weight);
        beats_sent++;
    endtask

    // Write the count register; a write also restarts loading at entry 0.
    task automatic write_count(logic [CNT_W-1:0] value);
        start        <= 1'b0;
        cfg_wr_en    <= 1'b1;
        vertex_count <= value;
        @(posedge clk);
        cfg_wr_en     <= 1'b0;
        count_setting  = value;
        load_slot      = 0;
        settings_written++;
    endtask

    // Drop start, let every due link arrive and the block fall idle.
    task automatic wait_idle();
        start <= 1'b0;
        @(posedge clk);
        while (links_due.size() != 0 || busy)
            @(posedge clk);
        repeat (4)
            @(posedge clk);
    endtask

    task automatic load_random_matrix(int n);
        int  density;
        bit  narrow;
        density = $urandom_range(0, 100);
        // Narrow weights make equal keys, and so tie breaks, common.
        narrow  = $urandom_range(0, 1);
        for (int i = 0; i < n * n; i++)
            send_edge($urandom_range(0, 99) < density,
                      narrow ? 16'($urandom_range(0, 7)) : 16'($urandom));
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // One vertex: a single entry yields a single root result. Zero runs as one.
    task automatic test_single_vertex();
        write_count(CNT_W'(1));
        send_edge(1'b1, 16'hA5A5);
        wait_idle();
        write_count('0);
        send_edge(1'b0, 16'h5A5A);
        wait_idle();
    endtask

    // Four vertices: weight extremes, a tie, a self edge, back edges to the
    // tree, an equal weight that must not replace a key, absent entries.
    task automatic test_weight_extremes();
        bit          present [16];
        logic [15:0] weight  [16];
        present = '{0, 1, 1, 0,  1, 1, 1, 0,  1, 0, 1, 1,  1, 1, 1, 1};
        weight  = '{16'hFFFF, 16'd5, 16'd5, 16'd0,
                    16'd0, 16'd0, 16'd5, 16'hFFFF,
                    16'd0, 16'd0, 16'd0, 16'hFFFF,
                    16'd0, 16'd0, 16'd0, 16'd0};
        write_count(CNT_W'(4));
        for (int i = 0; i < 16; i++)
            send_edge(present[i], weight[i]);
        wait_idle();
    endtask

    // Vertex 1 has only an edge into vertex 0, so it is never reached.
    task automatic test_unreachable();
        write_count(CNT_W'(2));
        send_edge(1'b0, 16'd9);
        send_edge(1'b0, 16'd3);
        send_edge(1'b1, 16'd7);
        send_edge(1'b0, 16'd1);
        wait_idle();
    endtask

    // Rewrite the count halfway through a matrix: loading starts over.
    task automatic test_reload_mid_matrix();
        write_count(CNT_W'(2));
        send_edge(1'b1, 16'd100);
        send_edge(1'b1, 16'd200);
        write_count(CNT_W'(2));
        send_edge(1'b0, 16'd0);
        send_edge(1'b1, 16'd4);
        send_edge(1'b1, 16'd2);
        send_edge(1'b0, 16'd0);
        wait_idle();
    endtask

    // Mostly whole matrices of small graphs with random content; now and then
    // a matrix cut short by a count write, and back-to-back matrices that hold
    // start high across the compute.
    task automatic test_random_graphs(int beat_budget, int idle_pct);
        int stop_at;
        int n;
        int cut;
        sender_idle_pct = idle_pct;
        stop_at         = beats_sent + beat_budget;
        while (beats_sent < stop_at)
        begin
            n = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 6) : $urandom_range(7, 12);
            if ($urandom_range(0, 9) == 0)
            begin
                write_count(CNT_W'(n));
                cut = $urandom_range(0, n * n - 1);
                for (int i = 0; i < cut; i++)
                    send_edge($urandom_range(0, 1), 16'($urandom));
            end
            write_count((n == 1 && $urandom_range(0, 1)) ? '0 : CNT_W'(n));
            repeat (($urandom_range(0, 3) == 0) ? 2 : 1)
                load_random_matrix(n);
            wait_idle();
        end
    endtask

    // A count above the maximum clamps to 32: a partial load there must not
    // start a run. Then restart with an eight-vertex matrix.
    task automatic test_count_clamp();
        sender_idle_pct = 0;
        write_count('1);
        for (int i = 0; i < 24; i++)
            send_edge($urandom_range(0, 1), 16'($urandom));
        write_count(CNT_W'(8));
        load_random_matrix(8);
        wait_idle();
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial
    begin
        rst_n            <= 1'b0;
        cfg_wr_en        <= 1'b0;
        vertex_count     <= '0;
        start            <= 1'b0;
        edge_present     <= 1'b0;
        edge_weight      <= '0;
        cycle_count       = 0;
        count_setting     = CNT_W'(1);
        load_slot         = 0;
        sender_idle_pct   = 0;
        beats_sent        = 0;
        links_checked     = 0;
        settings_written  = 0;
        fail_count        = 0;
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        sender_idle_pct = 15;
        test_single_vertex();
        test_weight_extremes();
        test_unreachable();
        test_reload_mid_matrix();

        test_random_graphs(80, 15);
        test_random_graphs(80, 88);
        test_random_graphs(80, 0);
        test_count_clamp();

        // Let any stray result beat show up before judging.
        wait_idle();
        repeat (TAIL_CYCLES)
            @(posedge clk);
        if (links_due.size() != 0)
        begin
            fail_count++;
            $display("%0d tree links never arrived", links_due.size());
        end

        $display("run covered %0d matrix beats and %0d tree links over %0d count writes,",
                 beats_sent, links_checked, settings_written);
        $display("graphs of 1 to 12 vertices with ties, gaps, clamps and restarts; %0d failures",
                 fail_count);
        if (fail_count == 0)
            $display("dense_prim_spanning_tree_core_tb passed");
        else
            $display("dense_prim_spanning_tree_core_tb failed");
        $finish;
    end

endmodule
